[rtl/swhl_pkg.sv]
// ----------------------------------------------------------------------------
// swhl_pkg
// Shared types and constants for the sliding window high/low channel.
// ----------------------------------------------------------------------------
package swhl_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int PRICE_WIDTH  = 32;
  localparam int LEN_W        = 7;
  localparam int ADDR_W       = $clog2(WINDOW_MAX);
  localparam int AGE_W        = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W       = ADDR_W + 2;
  localparam int WINDOW_RESET = 20;

  typedef logic signed [PRICE_WIDTH-1:0] price_t;

  typedef struct packed {
    price_t high_price;
    price_t low_price;
  } in_word_t;

  typedef struct packed {
    price_t channel_low;
    price_t channel_high;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    TRK_HOLD,
    TRK_CLEAR,
    TRK_LOAD,
    TRK_UPDATE,
    TRK_SCAN
  } trk_op_t;

  typedef struct packed {
    trk_op_t          op;
    logic             fill_zero;
    logic [AGE_W-1:0] win;
    logic             scan_valid;
    logic [AGE_W-1:0] scan_age;
  } trk_ctrl_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_ctrl_t;

endpackage

[rtl/swhl_ram.sv]
// ----------------------------------------------------------------------------
// swhl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swhl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/swhl_track.sv]
// ----------------------------------------------------------------------------
// swhl_track
// Running extreme tracker: holds the window max/min and their ages and
// owns the one compare pair used both for new words and for rescans.
// ----------------------------------------------------------------------------
module swhl_track (
  input  logic                clk,
  input  logic                rst,
  input  swhl_pkg::trk_ctrl_t trk,
  input  swhl_pkg::in_word_t  in_word,
  input  swhl_pkg::price_t    rd_high,
  input  swhl_pkg::price_t    rd_low,
  output logic                need_scan,
  output swhl_pkg::out_word_t result
);

  swhl_pkg::price_t                in_high;
  swhl_pkg::price_t                in_low;
  swhl_pkg::price_t                running_max;
  swhl_pkg::price_t                running_min;
  logic [swhl_pkg::AGE_W-1:0]      max_age;
  logic [swhl_pkg::AGE_W-1:0]      min_age;
  logic                            scan_max;
  logic                            scan_min;

  swhl_pkg::price_t                cand_high;
  swhl_pkg::price_t                cand_low;
  logic                            hi_ge;
  logic                            lo_le;
  logic [swhl_pkg::AGE_W-1:0]      max_age_inc;
  logic [swhl_pkg::AGE_W-1:0]      min_age_inc;
  logic                            max_exp;
  logic                            min_exp;

  // shared compare: new word during update, ram data during rescan
  always_comb begin
    cand_high   = (trk.op == swhl_pkg::TRK_SCAN) ? rd_high : in_high;
    cand_low    = (trk.op == swhl_pkg::TRK_SCAN) ? rd_low  : in_low;
    hi_ge       = cand_high >= running_max;
    lo_le       = cand_low  <= running_min;
    max_age_inc = max_age + 1'b1;
    min_age_inc = min_age + 1'b1;
    max_exp     = max_age_inc >= trk.win;
    min_exp     = min_age_inc >= trk.win;
    need_scan   = !trk.fill_zero && (max_exp || min_exp);
    result.channel_low  = running_min;
    result.channel_high = running_max;
  end

  always_ff @(posedge clk) begin
    if (trk.op == swhl_pkg::TRK_LOAD) begin
      in_high <= in_word.high_price;
      in_low  <= in_word.low_price;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      running_min <= '0;
      max_age     <= '0;
      min_age     <= '0;
      scan_max    <= 1'b0;
      scan_min    <= 1'b0;
    end else begin
      case (trk.op)
        swhl_pkg::TRK_CLEAR: begin
          running_max <= '0;
          running_min <= '0;
          max_age     <= '0;
          min_age     <= '0;
          scan_max    <= 1'b0;
          scan_min    <= 1'b0;
        end
        swhl_pkg::TRK_UPDATE: begin
          if (trk.fill_zero) begin
            running_max <= in_high;
            running_min <= in_low;
            max_age     <= '0;
            min_age     <= '0;
            scan_max    <= 1'b0;
            scan_min    <= 1'b0;
          end else begin
            scan_max <= max_exp;
            scan_min <= min_exp;
            if (!max_exp && hi_ge) begin
              running_max <= in_high;
              max_age     <= '0;
            end else begin
              max_age <= max_age_inc;
            end
            if (!min_exp && lo_le) begin
              running_min <= in_low;
              min_age     <= '0;
            end else begin
              min_age <= min_age_inc;
            end
          end
        end
        swhl_pkg::TRK_SCAN: begin
          // newest first; ties move to the older entry
          if (trk.scan_valid && scan_max && (trk.scan_age == '0 || hi_ge)) begin
            running_max <= rd_high;
            max_age     <= trk.scan_age;
          end
          if (trk.scan_valid && scan_min && (trk.scan_age == '0 || lo_le)) begin
            running_min <= rd_low;
            min_age     <= trk.scan_age;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/swhl_ctrl.sv]
// ----------------------------------------------------------------------------
// swhl_ctrl
// Sequencer: window register, ring pointer, fill count, rescan address
// walk and the output word register.
// ----------------------------------------------------------------------------
module swhl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [swhl_pkg::LEN_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swhl_pkg::out_word_t           out_word,
  input  swhl_pkg::out_word_t           result,
  input  logic                          need_scan,
  output swhl_pkg::trk_ctrl_t           trk,
  output swhl_pkg::ram_ctrl_t           ram
);

  swhl_pkg::state_t                state;
  swhl_pkg::state_t                state_next;
  logic [swhl_pkg::LEN_W-1:0]      window_len;
  logic [swhl_pkg::ADDR_W-1:0]     write_pos;
  logic [swhl_pkg::AGE_W-1:0]      fill_count;
  logic [swhl_pkg::AGE_W-1:0]      scan_cnt;
  logic                            rd_valid;
  logic [swhl_pkg::AGE_W-1:0]      rd_age;

  logic [swhl_pkg::AGE_W-1:0]      win;
  logic                            issue;
  logic                            load_out;
  logic [swhl_pkg::SLOT_W-1:0]     slot_sum;
  logic [swhl_pkg::SLOT_W-1:0]     slot_wrap;

  always_comb begin
    if (window_len == '0) begin
      win = swhl_pkg::AGE_W'(1);
    end else if (int'(window_len) > swhl_pkg::WINDOW_MAX) begin
      win = swhl_pkg::AGE_W'(swhl_pkg::WINDOW_MAX);
    end else begin
      win = swhl_pkg::AGE_W'(window_len);
    end
  end

  // slot of the entry scan_cnt words older than the newest
  always_comb begin
    slot_sum  = swhl_pkg::SLOT_W'(write_pos) + swhl_pkg::SLOT_W'(swhl_pkg::WINDOW_MAX - 1)
                - swhl_pkg::SLOT_W'(scan_cnt);
    slot_wrap = (slot_sum >= swhl_pkg::SLOT_W'(swhl_pkg::WINDOW_MAX)) ?
                slot_sum - swhl_pkg::SLOT_W'(swhl_pkg::WINDOW_MAX) : slot_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swhl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    issue          = 1'b0;
    load_out       = 1'b0;
    trk.op         = swhl_pkg::TRK_HOLD;
    trk.fill_zero  = fill_count == '0;
    trk.win        = win;
    trk.scan_valid = 1'b0;
    trk.scan_age   = rd_age;
    ram.wr_en      = 1'b0;
    ram.wr_addr    = write_pos;
    ram.rd_en      = 1'b0;
    ram.rd_addr    = swhl_pkg::ADDR_W'(slot_wrap);
    case (state)
      swhl_pkg::ST_IDLE: begin
        in_stall = cfg_wr_en;
        if (!cfg_wr_en && in_valid) begin
          ram.wr_en  = 1'b1;
          trk.op     = swhl_pkg::TRK_LOAD;
          state_next = swhl_pkg::ST_UPDATE;
        end
      end
      swhl_pkg::ST_UPDATE: begin
        trk.op     = swhl_pkg::TRK_UPDATE;
        state_next = need_scan ? swhl_pkg::ST_SCAN : swhl_pkg::ST_FINISH;
      end
      swhl_pkg::ST_SCAN: begin
        issue          = scan_cnt < win;
        ram.rd_en      = issue;
        trk.op         = swhl_pkg::TRK_SCAN;
        trk.scan_valid = rd_valid;
        if (!issue && !rd_valid) begin
          state_next = swhl_pkg::ST_FINISH;
        end
      end
      swhl_pkg::ST_FINISH: begin
        if (fill_count < win) begin
          state_next = swhl_pkg::ST_IDLE;
        end else if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = swhl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swhl_pkg::ST_IDLE;
      end
    endcase
    if (cfg_wr_en) begin
      trk.op = swhl_pkg::TRK_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swhl_pkg::LEN_W'(swhl_pkg::WINDOW_RESET);
      write_pos  <= '0;
      fill_count <= '0;
      scan_cnt   <= '0;
      rd_valid   <= 1'b0;
      rd_age     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_len <= cfg_wr_data;
        write_pos  <= '0;
        fill_count <= '0;
      end else begin
        if (ram.wr_en) begin
          write_pos <= (write_pos == swhl_pkg::ADDR_W'(swhl_pkg::WINDOW_MAX - 1)) ?
                       '0 : write_pos + 1'b1;
        end
        if (state == swhl_pkg::ST_UPDATE && fill_count < win) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (state == swhl_pkg::ST_UPDATE) begin
        scan_cnt <= '0;
        rd_valid <= 1'b0;
      end else if (state == swhl_pkg::ST_SCAN) begin
        if (issue) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        rd_valid <= issue;
        rd_age   <= scan_cnt;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word <= result;
    end
  end

endmodule

[rtl/sliding_window_high_low_channel.sv]
// ----------------------------------------------------------------------------
// sliding_window_high_low_channel
// Price channel over the last window_length bars: minimum of lows and
// maximum of highs, rescanning the ring stores when an extreme ages out.
//
//   port group   direction  handshake          payload
//   in_*         in         in_valid/in_stall  in_word (high_price, low_price)
//   out_*        out        out_valid/out_stall out_word (channel_low, channel_high)
//   cfg_*        in         cfg_wr_en          cfg_wr_data (window_length)
//
// a word is taken in idle, passes update, then scan when an extreme expires,
// and finish; scan reads window length (held to 1..64) entries, one per cycle
// no word is taken while one is in work; the result waits in an output
// register, so a new word is taken while it is stalled, and that word then
// holds in its last cycle until the output register frees
// reset clears the control state and sets window_length to 20
// ----------------------------------------------------------------------------
module sliding_window_high_low_channel (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [swhl_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  swhl_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output swhl_pkg::out_word_t        out_word
);

  swhl_pkg::trk_ctrl_t                 trk;
  swhl_pkg::ram_ctrl_t                 ram;
  swhl_pkg::out_word_t                 result;
  logic                                need_scan;
  logic [swhl_pkg::PRICE_WIDTH-1:0]    rd_high;
  logic [swhl_pkg::PRICE_WIDTH-1:0]    rd_low;

  swhl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .result      (result),
    .need_scan   (need_scan),
    .trk         (trk),
    .ram         (ram)
  );

  swhl_track u_track (
    .clk       (clk),
    .rst       (rst),
    .trk       (trk),
    .in_word   (in_word),
    .rd_high   (swhl_pkg::price_t'(rd_high)),
    .rd_low    (swhl_pkg::price_t'(rd_low)),
    .need_scan (need_scan),
    .result    (result)
  );

  swhl_ram #(
    .WIDTH (swhl_pkg::PRICE_WIDTH),
    .DEPTH (swhl_pkg::WINDOW_MAX)
  ) u_high_store (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (in_word.high_price),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (rd_high)
  );

  swhl_ram #(
    .WIDTH (swhl_pkg::PRICE_WIDTH),
    .DEPTH (swhl_pkg::WINDOW_MAX)
  ) u_low_store (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (in_word.low_price),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (rd_low)
  );

endmodule

[rtl/swhl_checker.sv]
// ----------------------------------------------------------------------------
// swhl_checker
// Port level checks for the high/low channel, bound to the top level.
// ----------------------------------------------------------------------------
module swhl_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input swhl_pkg::out_word_t out_word
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  // busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("word taken while previous word in work");

  // no result can appear the cycle after a word is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind sliding_window_high_low_channel swhl_checker u_swhl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[tb/sliding_window_high_low_channel_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_high_low_channel_tb
// Drives bars of high/low prices into the channel block under random idle
// gaps and output stalls, across several window lengths (zero, one, the
// maximum and beyond). A behavioral window tracker predicts the words that
// directed rows do not give; each is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module sliding_window_high_low_channel_tb;

  localparam int unsigned      CYCLE_LIMIT  = 1000000;
  localparam int unsigned      SETTLE       = 150;
  localparam int unsigned      HOLD_LEN     = 400;
  localparam int unsigned      RANDOM_BARS  = 1800;
  localparam swhl_pkg::price_t P_MAX        = 32'sh7fffffff;
  localparam swhl_pkg::price_t P_MIN        = 32'sh80000000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [swhl_pkg::LEN_W-1:0] len;
    swhl_pkg::price_t           high;
    swhl_pkg::price_t           low;
    logic                       typed;
    swhl_pkg::price_t           exp_low;
    swhl_pkg::price_t           exp_high;
  } dir_row_t;

  localparam dir_row_t DIRECTED [24] = '{
    '{ROW_ITEM, 7'd0,   32'sd100,      32'sd50,       1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,  -32'sd100,     -32'sd50,       1'b0, 32'sd0,        32'sd0},
    '{ROW_CFG,  7'd1,   32'sd0,        32'sd0,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   P_MAX,         P_MIN,         1'b1, P_MIN,         P_MAX},
    '{ROW_ITEM, 7'd0,   P_MIN,         P_MAX,         1'b1, P_MAX,         P_MIN},
    '{ROW_ITEM, 7'd0,   32'sd0,        32'sd0,        1'b1, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,  -32'sd1,       -32'sd1,        1'b1, -32'sd1,       -32'sd1},
    '{ROW_CFG,  7'd0,   32'sd0,        32'sd0,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sh7fff0000, 32'sh00010000, 1'b1, 32'sh00010000, 32'sh7fff0000},
    '{ROW_ITEM, 7'd0,   P_MIN,         P_MIN,         1'b1, P_MIN,         P_MIN},
    '{ROW_CFG,  7'd2,   32'sd0,        32'sd0,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd10,       32'sd5,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd20,       32'sd3,        1'b1, 32'sd3,        32'sd20},
    '{ROW_ITEM, 7'd0,   32'sd15,       32'sd4,        1'b1, 32'sd3,        32'sd20},
    '{ROW_ITEM, 7'd0,   32'sd15,       32'sd4,        1'b1, 32'sd4,        32'sd15},
    '{ROW_ITEM, 7'd0,   32'sd15,       32'sd4,        1'b1, 32'sd4,        32'sd15},
    '{ROW_CFG,  7'd3,   32'sd0,        32'sd0,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd7,       -32'sd7,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd7,       -32'sd7,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd9,       -32'sd9,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd1,       -32'sd1,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd1,       -32'sd1,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd1,       -32'sd1,        1'b0, 32'sd0,        32'sd0},
    '{ROW_ITEM, 7'd0,   32'sd1,       -32'sd1,        1'b0, 32'sd0,        32'sd0}
  };

  localparam logic [swhl_pkg::LEN_W-1:0] PHASE_LENS [9] = '{
    7'd127, 7'd64, 7'd1, 7'd0, 7'd65, 7'd2, 7'd20, 7'd33, 7'd7
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [swhl_pkg::LEN_W-1:0] cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  swhl_pkg::in_word_t         in_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  swhl_pkg::out_word_t        out_word;

  sliding_window_high_low_channel uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  // window tracker state
  swhl_pkg::price_t           hist_high [swhl_pkg::WINDOW_MAX];
  swhl_pkg::price_t           hist_low [swhl_pkg::WINDOW_MAX];
  int unsigned                wr_slot;
  int unsigned                filled;
  swhl_pkg::price_t           top_high;
  int unsigned                top_age;
  swhl_pkg::price_t           bottom_low;
  int unsigned                bottom_age;
  logic [swhl_pkg::LEN_W-1:0] span_reg;

  swhl_pkg::out_word_t        pending_channels [$];
  swhl_pkg::out_word_t        oldest_channel;
  int unsigned                error_count = 0;
  int unsigned                cycle_count = 0;
  bit                         quiet = 1'b0;
  bit                         hold_request = 1'b0;
  bit                         hold_done = 1'b0;
  swhl_pkg::price_t           high_level = 32'sd0;
  swhl_pkg::price_t           low_level = 32'sd0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sliding_window_high_low_channel_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, swhl_pkg::price_t got, swhl_pkg::price_t want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned window_eff();
    if (span_reg == '0) return 1;
    if (int'(span_reg) > swhl_pkg::WINDOW_MAX) return swhl_pkg::WINDOW_MAX;
    return 32'(span_reg);
  endfunction

  function automatic void restart_window();
    wr_slot    = 0;
    filled     = 0;
    top_high   = '0;
    top_age    = 0;
    bottom_low = '0;
    bottom_age = 0;
  endfunction

  // returns 1 when the bar completes a channel word
  function automatic bit track_bar(swhl_pkg::price_t hi, swhl_pkg::price_t lo,
                                   output swhl_pkg::out_word_t res);
    int unsigned span;
    int unsigned newest;
    int unsigned slot;
    int unsigned a;
    span = window_eff();
    hist_high[wr_slot] = hi;
    hist_low[wr_slot]  = lo;
    wr_slot = (wr_slot + 1) % swhl_pkg::WINDOW_MAX;
    newest  = (wr_slot + swhl_pkg::WINDOW_MAX - 1) % swhl_pkg::WINDOW_MAX;
    if (filled == 0) begin
      top_high   = hi;
      top_age    = 0;
      bottom_low = lo;
      bottom_age = 0;
    end else begin
      top_age++;
      if (top_age >= span) begin
        top_high = hist_high[newest];
        top_age  = 0;
        for (a = 1; a < span; a++) begin
          slot = (newest + swhl_pkg::WINDOW_MAX - a) % swhl_pkg::WINDOW_MAX;
          if (hist_high[slot] >= top_high) begin
            top_high = hist_high[slot];
            top_age  = a;
          end
        end
      end else if (hi >= top_high) begin
        top_high = hi;
        top_age  = 0;
      end
      bottom_age++;
      if (bottom_age >= span) begin
        bottom_low = hist_low[newest];
        bottom_age = 0;
        for (a = 1; a < span; a++) begin
          slot = (newest + swhl_pkg::WINDOW_MAX - a) % swhl_pkg::WINDOW_MAX;
          if (hist_low[slot] <= bottom_low) begin
            bottom_low = hist_low[slot];
            bottom_age = a;
          end
        end
      end else if (lo <= bottom_low) begin
        bottom_low = lo;
        bottom_age = 0;
      end
    end
    if (filled < span) filled++;
    res = '{channel_low: bottom_low, channel_high: top_high};
    return filled >= span;
  endfunction

  // trending walk with repeats, extremes and raw noise
  function automatic swhl_pkg::price_t next_price(ref swhl_pkg::price_t level);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 50) begin
      level = level + $signed($urandom_range(0, 2000)) - 32'sd1000;
      return level;
    end
    if (mode < 65) return level;
    if (mode < 75) begin
      case ($urandom_range(0, 3))
        0: return P_MAX;
        1: return P_MIN;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return swhl_pkg::price_t'($urandom);
  endfunction

  task automatic offer_bar(swhl_pkg::price_t hi, swhl_pkg::price_t lo, bit typed,
                           swhl_pkg::out_word_t typed_word);
    swhl_pkg::out_word_t predicted;
    bit                  produces;
    while (!quiet && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{high_price: hi, low_price: lo};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produces = track_bar(hi, lo, predicted);
    if (typed) pending_channels.push_back(typed_word);
    else if (produces) pending_channels.push_back(predicted);
  endtask

  // only while idle: drain, let any bar without a word finish, then write
  task automatic set_window(logic [swhl_pkg::LEN_W-1:0] len);
    in_valid <= 1'b0;
    while (pending_channels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    span_reg = len;
    restart_window();
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned hold_cycles;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 34);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_channels.size() == 0) begin
        report_mismatch("word with nothing expected, channel_low", out_word.channel_low, '0);
      end else begin
        oldest_channel = pending_channels.pop_front();
        if (out_word.channel_low !== oldest_channel.channel_low)
          report_mismatch("channel_low", out_word.channel_low, oldest_channel.channel_low);
        if (out_word.channel_high !== oldest_channel.channel_high)
          report_mismatch("channel_high", out_word.channel_high, oldest_channel.channel_high);
      end
    end
  end

  initial begin
    int unsigned                random_bars;
    int unsigned                phase;
    int unsigned                bar_count;
    int unsigned                i;
    logic [swhl_pkg::LEN_W-1:0] len;
    swhl_pkg::price_t           hi;
    swhl_pkg::price_t           lo;
    span_reg = swhl_pkg::LEN_W'(swhl_pkg::WINDOW_RESET);
    restart_window();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        set_window(DIRECTED[r].len);
      end else begin
        offer_bar(DIRECTED[r].high, DIRECTED[r].low, DIRECTED[r].typed,
                  '{channel_low: DIRECTED[r].exp_low, channel_high: DIRECTED[r].exp_high});
      end
    end

    random_bars = 0;
    phase = 0;
    while (random_bars < RANDOM_BARS) begin
      if (phase < 9) len = PHASE_LENS[phase];
      else if ($urandom_range(0, 1) == 1) len = swhl_pkg::LEN_W'($urandom_range(1, 12));
      else len = swhl_pkg::LEN_W'($urandom_range(0, 127));
      phase++;
      set_window(len);
      bar_count = 2 * window_eff() + $urandom_range(8, 48);
      for (i = 0; i < bar_count; i++) begin
        quiet = (random_bars >= 300) && (random_bars < 500);
        if (random_bars == 1000) hold_request = 1'b1;
        hi = next_price(high_level);
        lo = next_price(low_level);
        offer_bar(hi, lo, 1'b0, '0);
        random_bars++;
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending_channels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("sliding_window_high_low_channel_tb: PASS");
    end else begin
      $display("sliding_window_high_low_channel_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/swhl_pkg.sv
rtl/swhl_ram.sv
rtl/swhl_track.sv
rtl/swhl_ctrl.sv
rtl/sliding_window_high_low_channel.sv
rtl/swhl_checker.sv
tb/sliding_window_high_low_channel_tb.sv
